// File: rtl/core/spwm_pkg.sv
// Package: shared types, codes and the angle-to-level function for the servo PWM ramp block.
package spwm_pkg;

  // Item kinds carried in s_tuser
  typedef enum logic [1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_MOVE    = 2'd1,
    FUNC_SET     = 2'd2,
    FUNC_UNUSED  = 2'd3
  } func_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_PWM_WRAP     = 2'd0,
    REG_TICKS_PER_MS = 2'd1,
    REG_PWM_ENABLE   = 2'd2,
    REG_NONE         = 2'd3
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_MUL,
    ST_STEP,
    ST_OUT
  } seq_state_t;

  localparam logic [15:0] PwmWrapReset    = 16'd20000;
  localparam logic [15:0] TicksPerMsReset = 16'd1000;
  localparam int          DivBits         = 16;
  localparam int          LevelBase       = 500;
  // 2000/180 scaled by 2^16, rounded up; exact floor for angles 0..255
  localparam int          LevelRecip      = 728178;
  localparam int          LevelShift      = 16;
  localparam logic [11:0] LevelMax        = 12'd3333;

  // 500 + angle*2000/180, integer division, by reciprocal multiply
  function automatic logic [11:0] level_of(input logic [7:0] angle);
    logic [27:0] prod;
    prod = 28'(angle) * 28'(LevelRecip);
    return 12'(LevelBase) + 12'(prod >> LevelShift);
  endfunction

endpackage

// File: rtl/core/servo_pwm_ramp_generator.sv
// Servo PWM generator with linear ramp: sequencer around a restoring divider.
// From request accept to result valid, a plain item passes EXEC and OUT; a tick that
//   applies a ramp step adds STEP, and a smooth move that starts adds DIV, MUL and STEP.
// One item at a time; OUT holds while an unread result blocks the output, and the next
//   request is taken only after the result is loaded and the sequencer is back in idle.
// Reset (rst, synchronous): registers to wrap 20000, 1000 ticks/ms, PWM on; ramp and PWM state zero.
module servo_pwm_ramp_generator
  import spwm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input request
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // ramp_from[7:0], ramp_to[15:8], ramp_ms[31:16]
  input  logic [1:0]  s_tuser,   // func[1:0]
  // result
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // pin_level[0], pulse_width[12:1], current_angle[20:13],
                                 // busy_res[21], rejected[22], zero pad[23]
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration registers
  logic [15:0] pwm_wrap;
  logic [15:0] ticks_per_ms;
  logic        pwm_enable;

  // block state
  logic [15:0] pwm_count;
  logic [11:0] compare_level;
  logic [7:0]  angle_now;
  logic        going_down;
  logic [7:0]  steps_left;
  logic [31:0] hold_count;
  logic [31:0] hold_reload;
  logic        moving;

  // captured request
  func_t       func;
  logic [7:0]  ramp_from;
  logic [7:0]  ramp_to;
  logic [15:0] ramp_ms;
  logic        rejected;

  // divider
  logic [7:0]  div_rem;
  logic [15:0] div_quo;
  logic [3:0]  div_cnt;
  logic [8:0]  div_shift;
  logic [9:0]  div_diff;

  seq_state_t  state, state_next;

  logic [7:0]  steps_abs;
  logic [31:0] hold_dec;
  logic        tick_step;
  logic [7:0]  step_angle;
  logic        out_free;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;

  // divider step: shift in next dividend bit, trial subtract
  assign div_shift = {div_rem, div_quo[15]};
  assign div_diff  = {1'b0, div_shift} - {2'b00, steps_left};

  assign steps_abs  = (ramp_to > ramp_from) ? (ramp_to - ramp_from)
                                            : (ramp_from - ramp_to);
  assign hold_dec   = (hold_count != 32'd0) ? (hold_count - 32'd1) : hold_count;
  assign tick_step  = moving && (hold_dec == 32'd0) && (steps_left != 8'd0);
  assign step_angle = going_down ? (angle_now - 8'd1) : (angle_now + 8'd1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_OUT;
        case (func)
          FUNC_TICK: begin
            if (tick_step) state_next = ST_STEP;
          end
          FUNC_MOVE: begin
            if (!moving && steps_abs != 8'd0) state_next = ST_DIV;
          end
          default: state_next = ST_OUT;
        endcase
      end
      ST_DIV: begin
        if (div_cnt == 4'(DivBits - 1)) state_next = ST_MUL;
      end
      ST_MUL:  state_next = ST_STEP;
      ST_STEP: state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_wrap     <= PwmWrapReset;
      ticks_per_ms <= TicksPerMsReset;
      pwm_enable   <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_PWM_WRAP:     pwm_wrap     <= cfg_data;
        REG_TICKS_PER_MS: ticks_per_ms <= cfg_data;
        REG_PWM_ENABLE:   pwm_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      func      <= func_t'(s_tuser);
      ramp_from <= s_tdata[7:0];
      ramp_to   <= s_tdata[15:8];
      ramp_ms   <= s_tdata[31:16];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_count     <= '0;
      compare_level <= '0;
      angle_now     <= '0;
      going_down    <= 1'b0;
      steps_left    <= '0;
      hold_count    <= '0;
      hold_reload   <= '0;
      moving        <= 1'b0;
      rejected      <= 1'b0;
    end else begin
      case (state)
        ST_EXEC: begin
          rejected <= 1'b0;
          case (func)
            FUNC_TICK: begin
              if (pwm_enable) begin
                if (pwm_count >= pwm_wrap) pwm_count <= '0;
                else                       pwm_count <= pwm_count + 16'd1;
              end
              if (moving) begin
                hold_count <= hold_dec;
                // hold ran out with nothing left: final hold over
                if (hold_dec == 32'd0 && steps_left == 8'd0) moving <= 1'b0;
              end
            end
            FUNC_MOVE: begin
              if (moving) begin
                rejected <= 1'b1;
              end else if (steps_abs != 8'd0) begin
                going_down <= (ramp_to < ramp_from);
                angle_now  <= ramp_from;
                steps_left <= steps_abs;
                moving     <= 1'b1;
              end
            end
            FUNC_SET: begin
              if (moving) begin
                rejected <= 1'b1;
              end else begin
                angle_now     <= ramp_to;
                compare_level <= level_of(ramp_to);
              end
            end
            default: ;
          endcase
        end
        ST_MUL: hold_reload <= 32'(div_quo) * 32'(ticks_per_ms);
        ST_STEP: begin
          angle_now     <= step_angle;
          compare_level <= level_of(step_angle);
          steps_left    <= steps_left - 8'd1;
          hold_count    <= hold_reload;
        end
        default: ;
      endcase
    end
  end

  // restoring divider: ramp_ms / steps, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      div_rem <= '0;
      div_quo <= ramp_ms;
      div_cnt <= '0;
    end else if (state == ST_DIV) begin
      div_cnt <= div_cnt + 4'd1;
      if (!div_diff[9]) begin
        div_rem <= div_diff[7:0];
        div_quo <= {div_quo[14:0], 1'b1};
      end else begin
        div_rem <= div_shift[7:0];
        div_quo <= {div_quo[14:0], 1'b0};
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      m_tdata <= {1'b0, rejected, moving, angle_now, compare_level,
                  pwm_enable && ({4'b0, compare_level} > pwm_count)};
    end
  end

  // checks
  a_div_only_when_moving: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> moving)
    else $error("divider running without a move");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    compare_level <= LevelMax)
    else $error("compare level out of range");

  a_reject_means_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[22]) |-> m_tdata[21])
    else $error("rejected result while not busy");

  a_step_counts_down: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP) |=> (steps_left == $past(steps_left) - 8'd1))
    else $error("ramp step did not consume a step");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_EXEC))
    else $error("accepted request not executed");

endmodule

// File: tb/servo_pwm_ramp_generator_test.sv
// Self-checking testbench for the servo PWM ramp generator: directed cases, random traffic, then a busy-lockout run.
`timescale 1ns / 100ps

module servo_pwm_ramp_generator_test
  import spwm_pkg::*;
();

  localparam int ClkPeriod     = 12;
  localparam int ResetCycles   = 4;
  localparam int SettleCycles  = 4;
  localparam int EndCycles     = 30;
  localparam int WatchdogLimit = 4000;  // cycles with no handshake of any kind
  localparam int HoldCap       = 30;    // max ticks per ramp step in random moves

  // Status word as carried on m_tdata[22:0]; first member lands in the top bits
  typedef struct packed {
    logic        rejected;
    logic        busy_res;
    logic [7:0]  current_angle;
    logic [11:0] pulse_width;
    logic        pin_level;
  } servo_status_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata   = '0;
  logic [1:0]  s_tuser   = FUNC_TICK;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [23:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_PWM_WRAP;
  logic [15:0] cfg_data  = '0;

  servo_pwm_ramp_generator u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),    // ramp_from[7:0], ramp_to[15:8], ramp_ms[31:16]
    .s_tuser  (s_tuser),    // func[1:0]
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),    // pin_level[0], pulse_width[12:1], current_angle[20:13],
                            // busy_res[21], rejected[22], zero pad[23]
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Servo model: registers and state, all in the block's own widths.
  // Register values match the block's reset; state resets to zero.
  // ---------------------------------------------------------------------------
  logic [15:0] wrap_top    = PwmWrapReset;
  logic [15:0] tick_per_ms = TicksPerMsReset;
  logic        pwm_on      = 1'b1;

  logic [15:0] cnt_pwm     = '0;
  logic [11:0] level       = '0;
  logic [7:0]  angle       = '0;
  logic        dir_down    = 1'b0;
  logic [7:0]  steps_togo  = '0;
  logic [31:0] hold_ctr    = '0;
  logic [31:0] hold_len    = '0;
  logic        in_motion   = 1'b0;

  servo_status_t pending_status[$];   // expected status words, oldest first

  int requests_sent  = 0;
  int status_checked = 0;
  int moves_started  = 0;
  int cmds_rejected  = 0;
  int pin_high_seen  = 0;
  int mismatches     = 0;

  // Compare level for an angle: 500 + angle*2000/180, floor division
  function automatic logic [11:0] pulse_for_angle(input logic [7:0] a);
    return 12'(500 + (int'(a) * 2000) / 180);
  endfunction

  // One degree towards the target, then reload the hold
  function automatic void take_step();
    angle      = dir_down ? angle - 8'd1 : angle + 8'd1;
    level      = pulse_for_angle(angle);
    steps_togo = steps_togo - 8'd1;
    hold_ctr   = hold_len;
  endfunction

  // Applies one accepted request to the model and returns the status it should report
  function automatic servo_status_t advance_servo(input func_t f, input logic [7:0] a_start,
                                                  input logic [7:0] a_target,
                                                  input logic [15:0] dur);
    logic [7:0]    span;
    logic          rej;
    servo_status_t st;
    rej  = 1'b0;
    span = (a_target > a_start) ? a_target - a_start : a_start - a_target;
    case (f)
      FUNC_TICK: begin
        // counter freezes while PWM is off, but ramp timing keeps going
        if (pwm_on) cnt_pwm = (cnt_pwm >= wrap_top) ? 16'd0 : cnt_pwm + 16'd1;
        if (in_motion) begin
          if (hold_ctr != 0) hold_ctr = hold_ctr - 32'd1;
          if (hold_ctr == 0) begin
            if (steps_togo != 0) take_step();
            else in_motion = 1'b0;
          end
        end
      end
      FUNC_MOVE: begin
        if (in_motion) begin
          rej = 1'b1;
        end else if (span != 0) begin
          // first step is taken by the command itself
          dir_down   = a_target < a_start;
          angle      = a_start;
          steps_togo = span;
          hold_len   = (32'(dur) / 32'(span)) * 32'(tick_per_ms);
          in_motion  = 1'b1;
          take_step();
          moves_started++;
        end
      end
      FUNC_SET: begin
        if (in_motion) begin
          rej = 1'b1;
        end else begin
          angle = a_target;
          level = pulse_for_angle(a_target);
        end
      end
      default: ;  // unused kind: status only
    endcase
    if (rej) cmds_rejected++;
    st.pin_level     = pwm_on && (32'(cnt_pwm) < 32'(level));
    st.pulse_width   = level;
    st.current_angle = angle;
    st.busy_res      = in_motion;
    st.rejected      = rej;
    return st;
  endfunction

  // ---------------------------------------------------------------------------
  // Idling: a quarter of the time neither side idles; otherwise gaps are
  // mostly short with the odd long one.
  // ---------------------------------------------------------------------------
  logic [15:0] cycle_no = '0;
  wire         quiet    = cycle_no[8] & cycle_no[7];

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  int stall_left = 0;
  int stall_len;

  // Result-side back-pressure
  always @(posedge clk) begin
    cycle_no <= cycle_no + 16'd1;
    if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left  = stall_left - 1;
    end else begin
      stall_len = pick_gap();
      m_tready <= (stall_len == 0);
      if (stall_len != 0) stall_left = stall_len - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking: each accepted status against the oldest expectation
  // ---------------------------------------------------------------------------
  servo_status_t got_status, want_status;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_status = m_tdata[22:0];
      if (pending_status.size() == 0) begin
        $error("status result with no request waiting: %h", m_tdata);
        mismatches++;
      end else begin
        want_status = pending_status.pop_front();
        status_checked++;
        if (got_status.pin_level) pin_high_seen++;
        if (got_status.pin_level !== want_status.pin_level) begin
          $error("pin_level: expected %0d, got %0d", want_status.pin_level,
                 got_status.pin_level);
          mismatches++;
        end
        if (got_status.pulse_width !== want_status.pulse_width) begin
          $error("pulse_width: expected %0d, got %0d", want_status.pulse_width,
                 got_status.pulse_width);
          mismatches++;
        end
        if (got_status.current_angle !== want_status.current_angle) begin
          $error("current_angle: expected %0d, got %0d", want_status.current_angle,
                 got_status.current_angle);
          mismatches++;
        end
        if (got_status.busy_res !== want_status.busy_res) begin
          $error("busy_res: expected %0d, got %0d", want_status.busy_res,
                 got_status.busy_res);
          mismatches++;
        end
        if (got_status.rejected !== want_status.rejected) begin
          $error("rejected: expected %0d, got %0d", want_status.rejected,
                 got_status.rejected);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: any handshake restarts the count
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no handshake for %0d cycles, %0d status words outstanding",
               quiet_cycles, pending_status.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Request driving
  // ---------------------------------------------------------------------------

  // Sends one request; the model is advanced at the edge that accepts it.
  // tvalid is only lowered when a gap follows, so it never gets two updates in a step.
  task automatic send_request(input func_t f, input logic [7:0] a_start,
                              input logic [7:0] a_target, input logic [15:0] dur);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= {dur, a_target, a_start};
    do @(posedge clk); while (!s_tready);
    pending_status.push_back(advance_servo(f, a_start, a_target, dur));
    requests_sent++;
  endtask

  // Stop sending, wait for every status word, then let the sequencer go idle
  task automatic settle_block();
    s_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Register write, only ever issued with the block idle
  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] value);
    settle_block();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PWM_WRAP:     wrap_top    = value;
      REG_TICKS_PER_MS: tick_per_ms = value;
      REG_PWM_ENABLE:   pwm_on      = value[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Ticks with junk payload until the running move and its final hold are over
  task automatic finish_move();
    while (in_motion) send_request(FUNC_TICK, 8'($urandom), 8'($urandom), 16'($urandom));
  endtask

  // One random request. Mostly ticks, with well-formed moves with short holds so ramps
  // complete; while a move runs, mostly ticks plus the odd command to be refused.
  task automatic random_request();
    int          r;
    int          span;
    int          q;
    logic [7:0]  a0;
    logic [7:0]  a1;
    logic [15:0] dur;
    r   = $urandom_range(0, 99);
    a0  = 8'($urandom);
    a1  = 8'($urandom);
    dur = 16'($urandom);
    if (in_motion) begin
      if (r < 5)       send_request(FUNC_MOVE, a0, a1, dur);
      else if (r < 9)  send_request(FUNC_SET, a0, a1, dur);
      else if (r < 11) send_request(FUNC_UNUSED, a0, a1, dur);
      else             send_request(FUNC_TICK, a0, a1, dur);
    end else if (r < 14) begin
      span = (r < 2) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      if (($urandom_range(0, 1) == 1 && a0 >= span) || a0 + span > 255)
        a1 = 8'(a0 - span);
      else
        a1 = 8'(a0 + span);
      // keep (dur/steps)*ticks_per_ms within the hold cap
      q   = HoldCap / tick_per_ms;
      dur = 16'(span * $urandom_range(0, q) + $urandom_range(0, span - 1));
      send_request(FUNC_MOVE, a0, a1, dur);
    end else if (r < 22) begin
      if (r < 18) a1 = 8'($urandom_range(0, 10));  // low levels, near the counter range
      send_request(FUNC_SET, a0, a1, dur);
    end else if (r < 24) begin
      send_request(FUNC_MOVE, a0, a0, dur);      // no steps: does nothing
    end else if (r < 26) begin
      send_request(FUNC_UNUSED, a0, a1, dur);
    end else begin
      send_request(FUNC_TICK, a0, a1, dur);
    end
  endtask

  task automatic run_phase(input logic [15:0] wrap, input logic [15:0] tpm,
                           input logic en, input int count);
    write_reg(REG_PWM_WRAP, wrap);
    write_reg(REG_TICKS_PER_MS, tpm);
    write_reg(REG_PWM_ENABLE, 16'(en));
    repeat (count) random_request();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset defaults, instant angles at both ends and past 180, unused kind
  task automatic test_instant_angles();
    send_request(FUNC_TICK, 8'hFF, 8'hFF, 16'hFFFF);
    send_request(FUNC_SET, 8'h00, 8'd0, 16'h0000);
    send_request(FUNC_SET, 8'h00, 8'd180, 16'h0000);
    send_request(FUNC_SET, 8'hFF, 8'd255, 16'hFFFF);
    send_request(FUNC_UNUSED, 8'hFF, 8'hFF, 16'hFFFF);
  endtask

  // Zero-step move, zero-hold ramp up with refused commands, timed ramp down
  task automatic test_ramp_steps();
    write_reg(REG_TICKS_PER_MS, 16'd1);
    send_request(FUNC_MOVE, 8'd77, 8'd77, 16'hFFFF);
    send_request(FUNC_MOVE, 8'd10, 8'd12, 16'd0);
    send_request(FUNC_SET, 8'd0, 8'd40, 16'd0);
    send_request(FUNC_MOVE, 8'd0, 8'd255, 16'hFFFF);
    send_request(FUNC_UNUSED, 8'd0, 8'd0, 16'd0);
    finish_move();
    send_request(FUNC_MOVE, 8'd255, 8'd253, 16'd4);
    finish_move();
  endtask

  // Wrap lowered under the running count, then PWM off and on again
  task automatic test_wrap_and_enable();
    write_reg(REG_PWM_WRAP, 16'd3);
    repeat (3) send_request(FUNC_TICK, 8'($urandom), 8'($urandom), 16'($urandom));
    write_reg(REG_PWM_ENABLE, 16'd0);
    send_request(FUNC_TICK, 8'd0, 8'd0, 16'd0);
    send_request(FUNC_SET, 8'd0, 8'd90, 16'd0);
    write_reg(REG_PWM_ENABLE, 16'd1);
    send_request(FUNC_TICK, 8'd0, 8'd0, 16'd0);
  endtask

  // Random traffic over several register settings, extremes included
  task automatic test_random_traffic();
    run_phase(16'hFFFF, 16'd1, 1'b1, 420);      // counter climbs past the low levels
    run_phase(16'd560, 16'd2, 1'b1, 300);       // crosses 500..560, then wraps
    run_phase(16'd20000, 16'hFFFF, 1'b0, 150);  // PWM off, longest ms
    run_phase(16'd3, 16'd1, 1'b1, 150);         // wrap below the frozen count
    run_phase(16'd1, 16'd7, 1'b1, 100);         // shortest period
  endtask

  // Full-range move with the largest hold: other moves and sets are refused meanwhile
  task automatic test_busy_lockout();
    write_reg(REG_TICKS_PER_MS, 16'hFFFF);
    send_request(FUNC_MOVE, 8'd0, 8'd255, 16'hFFFF);
    repeat (30) random_request();
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_instant_angles();
    test_ramp_steps();
    test_wrap_and_enable();
    test_random_traffic();
    test_busy_lockout();

    settle_block();
    repeat (EndCycles) @(posedge clk);

    $display("%0d requests sent, %0d status words checked, %0d with the pin high",
             requests_sent, status_checked, pin_high_seen);
    $display("%0d ramps started, %0d commands refused while moving, %0d mismatches",
             moves_started, cmds_rejected, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/spwm_pkg.sv
rtl/core/servo_pwm_ramp_generator.sv
tb/servo_pwm_ramp_generator_test.sv
